[src/binary_pixel_packet_decoder_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the binary pixel packet decoder
// Shared property shapes used by the port checker.
// ----------------------------------------------------------------------------
`ifndef BINARY_PIXEL_PACKET_DECODER_CORE_ASSERT_SVH
`define BINARY_PIXEL_PACKET_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, reported by label.
`define BPPD_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, reported by label.
`define BPPD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/bppd_pkg.sv]
// ----------------------------------------------------------------------------
// bppd_pkg
// Types, constants and colour helpers shared by the packet decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bppd_pkg;

   localparam int MAX_PACKET_BYTES_DEFAULT = 1500;
   localparam logic [15:0] WIDTH_RESET  = 16'd64;
   localparam logic [15:0] HEIGHT_RESET = 16'd32;

   // Register indexes on the csr port
   localparam int REG_WIDTH  = 0;
   localparam int REG_HEIGHT = 1;

   // Packet format codes (byte 0)
   localparam logic [7:0] FMT_COORD16  = 8'd0;
   localparam logic [7:0] FMT_COORD12  = 8'd1;
   localparam logic [7:0] FMT_PACKED   = 8'd2;
   localparam logic [7:0] FMT_FIXED    = 8'd3;

   // Record lengths in bytes, without the alpha extension
   localparam logic [3:0] LEN_COORD16 = 4'd7;
   localparam logic [3:0] LEN_COORD12 = 4'd6;
   localparam logic [3:0] LEN_PACKED  = 4'd4;
   localparam logic [3:0] LEN_FIXED   = 4'd3;

   localparam int RECORD_BYTES = 7;
   localparam int ALPHA_BIT    = 0;
   localparam int QUEUE_DEPTH  = 2;

   typedef enum logic [1:0] {
      COLOR_DIRECT   = 2'd0,
      COLOR_RGB332   = 2'd1,
      COLOR_RGBA2222 = 2'd2
   } color_mode_type;

   typedef struct packed {
      logic [15:0]    x;
      logic [15:0]    y;
      color_mode_type mode;
      logic [7:0]     c0;
      logic [7:0]     c1;
      logic [7:0]     c2;
   } pixel_type;

   // 3-bit field times 31
   function automatic logic [7:0] scale3(input logic [2:0] v);
      logic [7:0] w;
      w = {5'd0, v};
      return (w << 5) - w;
   endfunction

   // 2-bit field times 63
   function automatic logic [7:0] scale2(input logic [1:0] v);
      logic [7:0] w;
      w = {6'd0, v};
      return (w << 6) - w;
   endfunction

endpackage

`default_nettype wire

[src/bppd_front.sv]
// ----------------------------------------------------------------------------
// bppd_front
// Byte parser: tracks packet position, collects records, checks coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

module bppd_front #(
   parameter int MAX_PACKET_BYTES = bppd_pkg::MAX_PACKET_BYTES_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire logic               in_ready,
   input  wire logic [7:0]         data_byte,
   input  wire logic               last_byte,
   input  wire logic [15:0]        screen_width,
   input  wire logic [15:0]        screen_height,
   output logic                    push_valid,
   output bppd_pkg::pixel_type     push_data
);

   localparam int POS_W = $clog2(MAX_PACKET_BYTES);
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_PACKET_BYTES - 1);
   localparam int RB = bppd_pkg::RECORD_BYTES;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       fmt_ff, fmt_in;
   logic [7:0]       flags_ff, flags_in;
   logic [2:0]       idx_ff, idx_in;
   logic             stopped_ff, stopped_in;
   logic [7:0]       store_ff [RB];

   logic       accept, active, in_records, known, alpha, complete, oob;
   logic [3:0] len, cnt;
   logic [7:0] rec [RB];
   logic [15:0] x, y;

   assign accept     = in_valid && in_ready;
   assign active     = pos_ff < POS_LIMIT;
   assign in_records = pos_ff >= POS_W'(2);
   assign known      = fmt_ff[7:2] == 6'd0;
   assign alpha      = flags_ff[bppd_pkg::ALPHA_BIT];
   assign cnt        = {1'b0, idx_ff} + 4'd1;

   always_comb begin
      case (fmt_ff)
         bppd_pkg::FMT_COORD16: len = bppd_pkg::LEN_COORD16 + {3'd0, alpha};
         bppd_pkg::FMT_COORD12: len = bppd_pkg::LEN_COORD12 + {3'd0, alpha};
         bppd_pkg::FMT_PACKED:  len = bppd_pkg::LEN_PACKED;
         bppd_pkg::FMT_FIXED:   len = bppd_pkg::LEN_FIXED;
         default:               len = 4'd0;
      endcase
   end

   // Record bytes as seen with the current byte merged in
   always_comb begin
      for (int i = 0; i < RB; i++) begin
         rec[i] = (idx_ff == 3'(i)) ? data_byte : store_ff[i];
      end
   end

   always_comb begin
      if (fmt_ff == bppd_pkg::FMT_COORD16) begin
         x = {rec[1], rec[0]};
         y = {rec[3], rec[2]};
      end else begin
         x = {4'd0, rec[1][3:0], rec[0]};
         y = {4'd0, rec[2], rec[1][7:4]};
      end
   end

   assign oob      = (x >= screen_width) || (y >= screen_height);
   assign complete = accept && active && in_records && !stopped_ff && known && (cnt >= len);
   assign push_valid = complete && !oob;

   always_comb begin
      push_data.x  = x;
      push_data.y  = y;
      push_data.c1 = 8'd0;
      push_data.c2 = 8'd0;
      case (fmt_ff)
         bppd_pkg::FMT_COORD16: begin
            push_data.mode = bppd_pkg::COLOR_DIRECT;
            push_data.c0   = rec[4];
            push_data.c1   = rec[5];
            push_data.c2   = rec[6];
         end
         bppd_pkg::FMT_COORD12: begin
            push_data.mode = bppd_pkg::COLOR_DIRECT;
            push_data.c0   = rec[3];
            push_data.c1   = rec[4];
            push_data.c2   = rec[5];
         end
         bppd_pkg::FMT_PACKED: begin
            push_data.mode = alpha ? bppd_pkg::COLOR_RGBA2222 : bppd_pkg::COLOR_RGB332;
            push_data.c0   = rec[3];
         end
         default: begin
            push_data.mode = bppd_pkg::COLOR_RGB332;
            push_data.c0   = flags_ff;
         end
      endcase
   end

   always_comb begin
      pos_in     = pos_ff;
      fmt_in     = fmt_ff;
      flags_in   = flags_ff;
      idx_in     = idx_ff;
      stopped_in = stopped_ff;
      if (accept) begin
         if (active) begin
            pos_in = pos_ff + POS_W'(1);
            if (pos_ff == POS_W'(0)) begin
               fmt_in = data_byte;
            end else if (pos_ff == POS_W'(1)) begin
               flags_in = data_byte;
               idx_in   = 3'd0;
            end else if (!stopped_ff && known) begin
               idx_in = (cnt < len) ? cnt[2:0] : 3'd0;
               if (complete && oob) begin
                  stopped_in = 1'b1;
               end
            end
         end
         if (last_byte) begin
            pos_in     = '0;
            idx_in     = 3'd0;
            stopped_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         fmt_ff     <= 8'd0;
         flags_ff   <= 8'd0;
         idx_ff     <= 3'd0;
         stopped_ff <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         fmt_ff     <= fmt_in;
         flags_ff   <= flags_in;
         idx_ff     <= idx_in;
         stopped_ff <= stopped_in;
      end
   end

   // Record bytes: payload only, written before they are read
   always_ff @(posedge clock) begin
      if (accept && active && in_records && !stopped_ff && known && idx_ff != 3'd7) begin
         store_ff[idx_ff] <= data_byte;
      end
   end

endmodule

`default_nettype wire

[src/bppd_queue.sv]
// ----------------------------------------------------------------------------
// bppd_queue
// Short pixel queue between the parser and the colour stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bppd_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   output logic                      push_ready,
   input  wire bppd_pkg::pixel_type  push_data,
   output logic                      pop_valid,
   input  wire logic                 pop_ready,
   output bppd_pkg::pixel_type       pop_data
);

   localparam int DEPTH = bppd_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bppd_pkg::pixel_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != CNT_W'(0);
   assign pop_data   = mem_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[src/bppd_back.sv]
// ----------------------------------------------------------------------------
// bppd_back
// Colour expansion and the registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bppd_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire bppd_pkg::pixel_type  in_data,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output logic [15:0]               pixel_x,
   output logic [15:0]               pixel_y,
   output logic [7:0]                red,
   output logic [7:0]                green,
   output logic [7:0]                blue
);

   logic        valid_ff, valid_in;
   logic [15:0] x_ff, y_ff;
   logic [7:0]  r_ff, g_ff, b_ff, r_in, g_in, b_in;
   logic        load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = load || (valid_ff && !out_ready);

   always_comb begin
      case (in_data.mode)
         bppd_pkg::COLOR_DIRECT: begin
            r_in = in_data.c0;
            g_in = in_data.c1;
            b_in = in_data.c2;
         end
         bppd_pkg::COLOR_RGBA2222: begin
            r_in = bppd_pkg::scale2(in_data.c0[7:6]);
            g_in = bppd_pkg::scale2(in_data.c0[5:4]);
            b_in = bppd_pkg::scale2(in_data.c0[3:2]);
         end
         default: begin
            r_in = bppd_pkg::scale3(in_data.c0[7:5]);
            g_in = bppd_pkg::scale3(in_data.c0[4:2]);
            b_in = bppd_pkg::scale2(in_data.c0[1:0]);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff <= in_data.x;
         y_ff <= in_data.y;
         r_ff <= r_in;
         g_ff <= g_in;
         b_ff <= b_in;
      end
   end

   assign out_valid = valid_ff;
   assign pixel_x   = x_ff;
   assign pixel_y   = y_ff;
   assign red       = r_ff;
   assign green     = g_ff;
   assign blue      = b_ff;

endmodule

`default_nettype wire

[src/binary_pixel_packet_decoder_core.sv]
// ----------------------------------------------------------------------------
// binary_pixel_packet_decoder_core
// Byte-serial decoder of binary pixel packets into pixel x, y and RGB colour.
// ----------------------------------------------------------------------------
// Takes one packet byte per clock on the req stream (tlast marks the final
// byte of a packet) and emits one pixel on the rsp stream for every complete,
// in-range record. Byte 0 selects the format (0: 16-bit coordinates with
// three colour bytes, 1: 12-bit coordinates with three colour bytes, 2: 12-bit
// coordinates with a packed RGB332 or RGBA2222 colour, 3: 12-bit coordinates
// with an RGB332 colour taken from the flags byte); byte 1 holds the flags,
// whose bit 0 lengthens formats 0 and 1 by one ignored byte and selects
// RGBA2222 in format 2. A coordinate at or past screen_width/screen_height
// drops the rest of the packet; unknown formats, partial last records and
// bytes beyond MAX_PACKET_BYTES-1 produce nothing. Throughput is one byte per
// cycle while the queue has room; a finished record's pixel goes through the
// queue and the output register to rsp. The queue, two entries deep, and the
// output register let the parser keep accepting while rsp is stalled, until
// the queue fills. screen_width sits at csr address 0x0, screen_height at 0x4
// (low address bits are ignored); write them only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_pixel_packet_decoder_core #(
   parameter int MAX_PACKET_BYTES = bppd_pkg::MAX_PACKET_BYTES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,   // last_byte
   // result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,   // [15:0] pixel_x, [31:16] pixel_y,
                                         // [39:32] red, [47:40] green, [55:48] blue
   // register port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic [15:0] width_ff, width_in, height_ff, height_in;
   logic        csr_write;
   logic        reg_sel;

   logic                push_valid, push_ready;
   bppd_pkg::pixel_type push_data;
   logic                pop_valid, pop_ready;
   bppd_pkg::pixel_type pop_data;

   logic [15:0] pixel_x, pixel_y;
   logic [7:0]  red, green, blue;

   // Register port: zero wait states, word index from address bit 2
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         if (reg_sel == 1'(bppd_pkg::REG_HEIGHT)) begin
            height_in = csr_pwdata[15:0];
         end else begin
            width_in = csr_pwdata[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bppd_pkg::WIDTH_RESET;
         height_ff <= bppd_pkg::HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign csr_prdata = (reg_sel == 1'(bppd_pkg::REG_HEIGHT)) ? {16'd0, height_ff}
                                                             : {16'd0, width_ff};

   // Accept a byte whenever the queue has room, even with no pixel due
   assign req_tready = push_ready;

   bppd_front #(
      .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (push_ready),
      .data_byte     (req_tdata),
      .last_byte     (req_tlast),
      .screen_width  (width_ff),
      .screen_height (height_ff),
      .push_valid    (push_valid),
      .push_data     (push_data)
   );

   bppd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   bppd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pop_valid),
      .in_ready  (pop_ready),
      .in_data   (pop_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .pixel_x   (pixel_x),
      .pixel_y   (pixel_y),
      .red       (red),
      .green     (green),
      .blue      (blue)
   );

   assign rsp_tdata = {blue, green, red, pixel_y, pixel_x};

endmodule

`default_nettype wire

[src/bppd_checker.sv]
// ----------------------------------------------------------------------------
// bppd_checker
// Port-level checks for the pixel packet decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "binary_pixel_packet_decoder_core_assert.svh"

module bppd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [55:0] rsp_tdata,
   input wire logic        csr_psel,
   input wire logic        csr_pready
);

   logic req_fire;
   assign req_fire = req_tvalid && req_tready;

   // Hold a stalled pixel unchanged
   `BPPD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp payload changed under stall")

   // Drop the output after reset
   `BPPD_ASSERT_NEXT(a_rsp_reset, clock, 1'b0, reset, !rsp_tvalid, "rsp valid right after reset")

   // A fresh pixel must come from a byte accepted on req, via the queue and output register
   `BPPD_ASSERT_IMPL(a_rsp_origin, clock, reset, $rose(rsp_tvalid), $past(req_fire, 2), "pixel without a matching request")

   // Register port never waits
   `BPPD_ASSERT_IMPL(a_csr_ready, clock, reset, csr_psel, csr_pready, "csr port inserted a wait state")

endmodule

bind binary_pixel_packet_decoder_core bppd_checker u_bppd_checker (.*);

`default_nettype wire

[tb/binary_pixel_packet_decoder_core_test.sv]
// ----------------------------------------------------------------------------
// binary_pixel_packet_decoder_core_test
// Self-checking bench for the byte-serial pixel packet decoder.
// ----------------------------------------------------------------------------
// Feeds packet bytes on the req stream and checks every pixel on the rsp
// stream, field by field, against an in-bench decoder or a typed-in pixel.
// A short table of hand-built packets runs first at the reset screen size;
// then random packets (mostly well-formed, some truncated, unknown or noise)
// run under a series of screen sizes. Both streams idle at random.
// ----------------------------------------------------------------------------
module binary_pixel_packet_decoder_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASE_BYTES  = 70;    // decoded bytes per random phase
   localparam int SETTLE_CYCLES = 8;    // pipeline + queue + output register
   localparam int IDLE_LIMIT   = 4000;  // cycles with no handshake at all
   localparam int PARK_CYCLES  = 300;   // long receiver hold-off

   // Pixel laid out exactly as rsp_tdata: x in the low bits, blue on top
   typedef struct packed {
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
      logic [15:0] y;
      logic [15:0] x;
   } dot_type;

   // How a request's result is predicted
   typedef enum logic [1:0] {
      ROW_MODEL,   // from the in-bench decoder
      ROW_NONE,    // typed in: no pixel
      ROW_PIXEL    // typed in: the given pixel
   } row_kind_type;

   typedef struct {
      logic [7:0]   data;
      logic         tl;
      row_kind_type kind;
      dot_type      px;
   } step_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Side info that travels with each request, driven alongside req_tdata
   row_kind_type row_kind;
   dot_type      row_px;

   binary_pixel_packet_decoder_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Decoder state mirrored in the bench
   // ------------------------------------------------------------------------
   logic [15:0] scr_w = bppd_pkg::WIDTH_RESET;
   logic [15:0] scr_h = bppd_pkg::HEIGHT_RESET;
   logic [10:0] pos_cnt = '0;
   logic [7:0]  fmt_code = '0;
   logic [7:0]  hdr_flags = '0;
   logic [2:0]  rec_cnt = '0;
   logic [7:0]  rec_buf [bppd_pkg::RECORD_BYTES];
   logic        halted = 1'b0;

   dot_type     pending_pixels [$];   // pixels the block still owes
   int          decoded_bytes = 0;    // header and record bytes the parser decoded
   int          err_count = 0;
   int          idle_cycles = 0;
   bit          park_rsp = 1'b0;      // ask the receiver for a long hold-off
   bit          steady = 1'b0;        // sender offers back to back
   logic [7:0]  pkt_bytes [$];        // packet under construction

   function automatic int rec_length();
      int alpha;
      alpha = int'(hdr_flags[bppd_pkg::ALPHA_BIT]);
      case (fmt_code)
         bppd_pkg::FMT_COORD16: return int'(bppd_pkg::LEN_COORD16) + alpha;
         bppd_pkg::FMT_COORD12: return int'(bppd_pkg::LEN_COORD12) + alpha;
         bppd_pkg::FMT_PACKED:  return int'(bppd_pkg::LEN_PACKED);
         bppd_pkg::FMT_FIXED:   return int'(bppd_pkg::LEN_FIXED);
         default:               return 0;
      endcase
   endfunction

   // Advance the mirrored state by one packet byte; hit says a pixel is due
   function automatic void decode_byte(input logic [7:0] b, input logic tl,
                                       output bit hit, output dot_type px);
      int         len;
      int         cnt;
      int         off;
      logic [7:0] c;
      hit = 1'b0;
      px  = '0;
      if (int'(pos_cnt) < bppd_pkg::MAX_PACKET_BYTES_DEFAULT - 1) begin
         pos_cnt = pos_cnt + 11'd1;
         if (pos_cnt == 11'd1) begin
            fmt_code = b;
            decoded_bytes++;
         end else if (pos_cnt == 11'd2) begin
            hdr_flags = b;
            rec_cnt = '0;
            decoded_bytes++;
         end else if (!halted && fmt_code <= bppd_pkg::FMT_FIXED) begin
            decoded_bytes++;
            len = rec_length();
            if (int'(rec_cnt) < bppd_pkg::RECORD_BYTES) rec_buf[rec_cnt] = b;
            cnt = int'(rec_cnt) + 1;
            if (cnt < len) begin
               rec_cnt = 3'(cnt);
            end else begin
               rec_cnt = '0;
               if (fmt_code == bppd_pkg::FMT_COORD16) begin
                  px.x = {rec_buf[1], rec_buf[0]};
                  px.y = {rec_buf[3], rec_buf[2]};
               end else begin
                  px.x = {4'd0, rec_buf[1][3:0], rec_buf[0]};
                  px.y = {4'd0, rec_buf[2], rec_buf[1][7:4]};
               end
               if (px.x >= scr_w || px.y >= scr_h) begin
                  halted = 1'b1;
               end else begin
                  hit = 1'b1;
                  if (fmt_code == bppd_pkg::FMT_COORD16 ||
                      fmt_code == bppd_pkg::FMT_COORD12) begin
                     off = (fmt_code == bppd_pkg::FMT_COORD16) ? 4 : 3;
                     px.red   = rec_buf[off];
                     px.green = rec_buf[off + 1];
                     px.blue  = rec_buf[off + 2];
                  end else begin
                     // packed colour from the record, fixed colour from the flags
                     c = (fmt_code == bppd_pkg::FMT_PACKED) ? rec_buf[3] : hdr_flags;
                     if (fmt_code == bppd_pkg::FMT_PACKED &&
                         hdr_flags[bppd_pkg::ALPHA_BIT]) begin
                        px.red   = 8'(c[7:6] * 63);
                        px.green = 8'(c[5:4] * 63);
                        px.blue  = 8'(c[3:2] * 63);
                     end else begin
                        px.red   = 8'(c[7:5] * 31);
                        px.green = 8'(c[4:2] * 31);
                        px.blue  = 8'(c[1:0] * 63);
                     end
                  end
               end
            end
         end
      end
      // the final byte may still complete a record, so clear afterwards
      if (tl) begin
         pos_cnt = '0;
         rec_cnt = '0;
         halted  = 1'b0;
      end
   endfunction

   task automatic report_mismatch(input string what, input longint got,
                                  input longint want);
      err_count++;
      $display("%0t mismatch %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
   endtask

   // ------------------------------------------------------------------------
   // Checker and watchdog: sample both streams at the rising edge
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      dot_type got;
      dot_type want;
      dot_type guess;
      bit      hit;
      if (rsp_tvalid && rsp_tready) begin
         got = dot_type'(rsp_tdata);
         if (pending_pixels.size() == 0) begin
            report_mismatch("unexpected pixel", longint'(rsp_tdata), 0);
         end else begin
            want = pending_pixels.pop_front();
            if (got.x != want.x)         report_mismatch("pixel_x", got.x, want.x);
            if (got.y != want.y)         report_mismatch("pixel_y", got.y, want.y);
            if (got.red != want.red)     report_mismatch("red", got.red, want.red);
            if (got.green != want.green) report_mismatch("green", got.green, want.green);
            if (got.blue != want.blue)   report_mismatch("blue", got.blue, want.blue);
         end
      end
      // predict after checking: a pixel never leaves in its own request cycle
      if (req_tvalid && req_tready) begin
         decode_byte(req_tdata, req_tlast, hit, guess);
         case (row_kind)
            ROW_MODEL: if (hit) pending_pixels.push_back(guess);
            ROW_PIXEL: pending_pixels.push_back(row_px);
            default: ;
         endcase
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else if (++idle_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // ------------------------------------------------------------------------
   // Receiver: random back-pressure, one long hold-off on request
   // ------------------------------------------------------------------------
   initial begin : receiver
      int lo;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (park_rsp) begin
            park_rsp = 1'b0;
            lo = PARK_CYCLES;
         end else begin
            lo = idle_len();
         end
         if (lo > 0) begin
            rsp_tready <= 1'b0;
            repeat (lo) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         // occasionally hold ready high for a long stretch
         if ($urandom_range(0, 9) == 0) repeat ($urandom_range(50, 150)) @(negedge clock);
         else repeat ($urandom_range(0, 12)) @(negedge clock);
      end
   end

   // ------------------------------------------------------------------------
   // Sender helpers
   // ------------------------------------------------------------------------
   // Offer one request and hold it until accepted
   task automatic offer(input logic [7:0] d, input logic tl, input row_kind_type k,
                        input dot_type px);
      int gap;
      gap = steady ? 0 : idle_len();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tlast  <= tl;
      row_kind   <= k;
      row_px     <= px;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Drop valid, wait for every owed pixel, then let the pipeline empty
   task automatic quiesce();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input int idx, input logic [15:0] val);
      logic [31:0] word;
      word = $urandom();
      word[15:0] = val;   // upper bits are don't-care for a 16-bit register
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 3'(idx * 4);
      csr_pwdata  <= word;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (idx == bppd_pkg::REG_WIDTH) scr_w = val;
      else scr_h = val;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Mostly in range, biased to the edge; otherwise out of range or the limit itself
   function automatic logic [15:0] pick_coord(input logic [15:0] lim, input bit narrow);
      int span;
      int top;
      int r;
      span = narrow ? 4096 : 65536;
      r = $urandom_range(0, 99);
      if (lim == 16'd0 || r >= 85) begin
         if (r >= 93 && int'(lim) < span) return lim;
         return narrow ? {4'd0, 12'($urandom())} : 16'($urandom());
      end
      top = (int'(lim) > span) ? span - 1 : int'(lim) - 1;
      if (r < 15) return 16'(top);
      return 16'($urandom_range(0, top));
   endfunction

   task automatic add_record(input logic [7:0] fmt, input bit alpha);
      logic [15:0] x;
      logic [15:0] y;
      x = pick_coord(scr_w, fmt != bppd_pkg::FMT_COORD16);
      y = pick_coord(scr_h, fmt != bppd_pkg::FMT_COORD16);
      if (fmt == bppd_pkg::FMT_COORD16) begin
         pkt_bytes.push_back(x[7:0]);
         pkt_bytes.push_back(x[15:8]);
         pkt_bytes.push_back(y[7:0]);
         pkt_bytes.push_back(y[15:8]);
      end else begin
         pkt_bytes.push_back(x[7:0]);
         pkt_bytes.push_back({y[3:0], x[11:8]});
         pkt_bytes.push_back(y[11:4]);
      end
      if (fmt == bppd_pkg::FMT_COORD16 || fmt == bppd_pkg::FMT_COORD12) begin
         repeat (3) pkt_bytes.push_back(8'($urandom()));
         if (alpha) pkt_bytes.push_back(8'($urandom()));
      end else if (fmt == bppd_pkg::FMT_PACKED) begin
         pkt_bytes.push_back(8'($urandom()));
      end
   endtask

   task automatic push_packet();
      foreach (pkt_bytes[i])
         offer(pkt_bytes[i], i == pkt_bytes.size() - 1, ROW_MODEL, '0);
   endtask

   // Build and send one random packet: mostly well formed, some broken
   task automatic send_packet();
      int         kind;
      int         nrec;
      logic [7:0] fmt;
      logic [7:0] flags;
      pkt_bytes.delete();
      steady = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
         // noise of random length
         repeat ($urandom_range(1, 20)) pkt_bytes.push_back(8'($urandom()));
      end else begin
         fmt   = (kind < 13) ? 8'($urandom_range(4, 255)) : 8'($urandom_range(0, 3));
         flags = 8'($urandom());
         pkt_bytes.push_back(fmt);
         if (kind >= 16) begin   // a few packets stop after the format byte
            pkt_bytes.push_back(flags);
            nrec = $urandom_range(0, 5);
            repeat (nrec) add_record(fmt > bppd_pkg::FMT_FIXED ? bppd_pkg::FMT_COORD16 : fmt,
                                     flags[bppd_pkg::ALPHA_BIT]);
            kind = $urandom_range(0, 99);
            if (kind < 15 && pkt_bytes.size() > 3) begin
               // partial last record
               repeat ($urandom_range(1, 3)) void'(pkt_bytes.pop_back());
            end else if (kind < 20) begin
               repeat ($urandom_range(1, 6)) pkt_bytes.push_back(8'($urandom()));
            end
         end
      end
      push_packet();
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   step_row_type plan [27];
   logic [15:0]  plan_w [8];
   logic [15:0]  plan_h [8];

   function automatic dot_type dot(input logic [15:0] x, input logic [15:0] y,
                                   input logic [7:0] r, input logic [7:0] g,
                                   input logic [7:0] b);
      dot_type d;
      d.x = x; d.y = y; d.red = r; d.green = g; d.blue = b;
      return d;
   endfunction

   initial begin : stimulus
      int  mark;
      bit  drained;
      // drive every input to a known value
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      row_kind    = ROW_MODEL;
      row_px      = '0;

      plan = '{
         // format 0, no alpha: x=5 y=3, colour bytes passed through
         '{8'h00, 1'b0, ROW_MODEL, '0}, '{8'h00, 1'b0, ROW_MODEL, '0},
         '{8'h05, 1'b0, ROW_MODEL, '0}, '{8'h00, 1'b0, ROW_MODEL, '0},
         '{8'h03, 1'b0, ROW_MODEL, '0}, '{8'h00, 1'b0, ROW_MODEL, '0},
         '{8'hFF, 1'b0, ROW_MODEL, '0}, '{8'h00, 1'b0, ROW_MODEL, '0},
         '{8'h80, 1'b1, ROW_PIXEL, dot(16'd5, 16'd3, 8'hFF, 8'h00, 8'h80)},
         // format 3, white from the flags at the screen corner, then x at width
         '{8'h03, 1'b0, ROW_MODEL, '0}, '{8'hFF, 1'b0, ROW_MODEL, '0},
         '{8'h3F, 1'b0, ROW_MODEL, '0}, '{8'hF0, 1'b0, ROW_MODEL, '0},
         '{8'h01, 1'b0, ROW_PIXEL, dot(16'd63, 16'd31, 8'hD9, 8'hD9, 8'hBD)},
         '{8'h40, 1'b0, ROW_MODEL, '0}, '{8'h00, 1'b0, ROW_MODEL, '0},
         '{8'h00, 1'b1, ROW_NONE, '0},
         // unknown format: whole packet ignored
         '{8'hFF, 1'b0, ROW_NONE, '0}, '{8'h00, 1'b0, ROW_NONE, '0},
         '{8'h00, 1'b1, ROW_NONE, '0},
         // packet of one byte
         '{8'h02, 1'b1, ROW_NONE, '0},
         // format 2 with alpha: RGBA2222, all fields full scale
         '{8'h02, 1'b0, ROW_MODEL, '0}, '{8'h01, 1'b0, ROW_MODEL, '0},
         '{8'h00, 1'b0, ROW_MODEL, '0}, '{8'h00, 1'b0, ROW_MODEL, '0},
         '{8'h00, 1'b0, ROW_MODEL, '0},
         '{8'hFC, 1'b1, ROW_PIXEL, dot(16'd0, 16'd0, 8'hBD, 8'hBD, 8'hBD)}
      };

      // screen sizes per random phase: extremes, zero, the 12-bit edge
      plan_w = '{16'hFFFF, 16'd1, 16'($urandom_range(1, 4095)), 16'd0,
                 16'd4096, 16'd200, 16'($urandom_range(1, 65535)),
                 bppd_pkg::WIDTH_RESET};
      plan_h = '{16'hFFFF, 16'd1, 16'($urandom_range(1, 4095)), 16'd200,
                 16'd4096, 16'd0, 16'($urandom_range(1, 65535)),
                 bppd_pkg::HEIGHT_RESET};

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table at the reset screen size
      foreach (plan[i]) offer(plan[i].data, plan[i].tl, plan[i].kind, plan[i].px);
      quiesce();

      foreach (plan_w[ph]) begin
         csr_write(bppd_pkg::REG_WIDTH, plan_w[ph]);
         csr_write(bppd_pkg::REG_HEIGHT, plan_h[ph]);
         // in phase 1 park the receiver so the block backs up into req;
         // hold the sender until the hold-off has really begun
         if (ph == 1) begin
            park_rsp = 1'b1;
            wait (!park_rsp);
         end
         mark = decoded_bytes;
         drained = 1'b0;
         while (decoded_bytes - mark < PHASE_BYTES) begin
            send_packet();
            // in phase 2 pause the sender mid-phase until all pixels are out
            if (ph == 2 && !drained && decoded_bytes - mark > PHASE_BYTES / 2) begin
               quiesce();
               drained = 1'b1;
            end
         end
         quiesce();
      end

      repeat (20) @(posedge clock);
      if (pending_pixels.size() != 0)
         report_mismatch("pixels never delivered", pending_pixels.size(), 0);
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[binary_pixel_packet_decoder_core.f]
+incdir+src
src/bppd_pkg.sv
src/bppd_front.sv
src/bppd_queue.sv
src/bppd_back.sv
src/binary_pixel_packet_decoder_core.sv
src/bppd_checker.sv
tb/binary_pixel_packet_decoder_core_test.sv
